@@ rtl/core/met_pkg.sv @@
package met_pkg;

    // field widths
    localparam int ANGLE_W    = 12;
    localparam int DT_W       = 16;
    localparam int TURN_OUT_W = 16;
    localparam int POS_W      = 28;
    localparam int VEL_W      = 32;

    // velocity datapath
    localparam int US_W    = 21;                  // signed width holding 1e6
    localparam int DELTA_W = POS_W + 1;
    localparam int PROD_W  = DELTA_W + US_W - 1;  // |delta * 1e6| < 2^48
    localparam int MAG_W   = PROD_W - 1;
    localparam int QUOT_W  = VEL_W;
    localparam int CNT_W   = $clog2(QUOT_W);

    localparam logic signed [US_W-1:0] US_PER_S = 21'sd1000000;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic signed [TURN_OUT_W-1:0] TURN_OUT_MAX = {1'b0, {(TURN_OUT_W-1){1'b1}}};
    localparam logic signed [TURN_OUT_W-1:0] TURN_OUT_MIN = {1'b1, {(TURN_OUT_W-1){1'b0}}};

    localparam logic [ANGLE_W-1:0] WRAP_THR_RESET = 12'd3276;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic upd_turn;
        logic pos_mul;
        logic pos_sum;
        logic vel_mul;
        logic div_init;
        logic div_step;
        logic vel_fin;
        logic out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic read_ok;
        logic dt_zero;
        logic div_sat;
        logic div_last;
    } dp_status_t;

endpackage

@@ rtl/core/met_in_if.sv @@
interface met_in_if;
    import met_pkg::*;

    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] raw_angle;
    logic               read_ok;
    logic [DT_W-1:0]    elapsed_us;

    modport source (output valid, output raw_angle, output read_ok, output elapsed_us,
                    input ready);
    modport sink   (input valid, input raw_angle, input read_ok, input elapsed_us,
                    output ready);
endinterface

@@ rtl/core/met_out_if.sv @@
interface met_out_if;
    import met_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [ANGLE_W-1:0]           angle_counts;
    logic signed [TURN_OUT_W-1:0] turn_count;
    logic signed [POS_W-1:0]      position_counts;
    logic signed [VEL_W-1:0]      velocity_cps;
    logic                         fault;

    modport source (output valid, output angle_counts, output turn_count,
                    output position_counts, output velocity_cps, output fault,
                    input ready);
    modport sink   (input valid, input angle_counts, input turn_count,
                    input position_counts, input velocity_cps, input fault,
                    output ready);
endinterface

@@ rtl/core/met_ctrl.sv @@
module met_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  met_pkg::dp_status_t status,
    output met_pkg::dp_cmd_t    cmd
);
    import met_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TURN  = 4'd1;
    localparam logic [3:0] S_PMUL  = 4'd2;
    localparam logic [3:0] S_PSUM  = 4'd3;
    localparam logic [3:0] S_VMUL  = 4'd4;
    localparam logic [3:0] S_DINIT = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_VFIN  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_TURN;
                end
            end
            S_TURN:
            begin
                if (status.read_ok)
                begin
                    cmd.upd_turn = 1'b1;
                    state_next   = S_PMUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PMUL:
            begin
                cmd.pos_mul = 1'b1;
                state_next  = S_PSUM;
            end
            S_PSUM:
            begin
                cmd.pos_sum = 1'b1;
                state_next  = status.dt_zero ? S_DONE : S_VMUL;
            end
            S_VMUL:
            begin
                cmd.vel_mul = 1'b1;
                state_next  = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = status.div_sat ? S_VFIN : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_VFIN;
                end
            end
            S_VFIN:
            begin
                cmd.vel_fin = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/met_dp.sv @@
module met_dp #(
    parameter int COUNTS_PER_REV = 4096,
    parameter int TURN_BITS      = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [met_pkg::ANGLE_W-1:0]           cfg_wdata,
    input  met_pkg::dp_cmd_t                      cmd,
    output met_pkg::dp_status_t                   status,
    input  logic [met_pkg::ANGLE_W-1:0]           in_raw_angle,
    input  logic                                  in_read_ok,
    input  logic [met_pkg::DT_W-1:0]              in_elapsed_us,
    output logic [met_pkg::ANGLE_W-1:0]           angle_counts,
    output logic signed [met_pkg::TURN_OUT_W-1:0] turn_count,
    output logic signed [met_pkg::POS_W-1:0]      position_counts,
    output logic signed [met_pkg::VEL_W-1:0]      velocity_cps,
    output logic                                  fault
);
    import met_pkg::*;

    localparam int CPR_W = $clog2(COUNTS_PER_REV + 1);
    localparam int MUL_W = TURN_BITS + CPR_W + 1;
    localparam int SUM_W = (MUL_W > POS_W) ? MUL_W + 1 : POS_W + 1;
    localparam int TX_W  = (TURN_BITS > TURN_OUT_W) ? TURN_BITS : TURN_OUT_W;

    localparam logic signed [CPR_W:0] CPR_S = (CPR_W + 1)'(COUNTS_PER_REV);
    localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
    localparam logic [QUOT_W-1:0] QUO_NEG_LIMIT = {1'b1, {(QUOT_W-1){1'b0}}};

    // architectural state
    logic [ANGLE_W-1:0]          thr_reg;
    logic [ANGLE_W-1:0]          prev_raw_reg,  prev_raw_next;
    logic signed [TURN_BITS-1:0] turns_reg,     turns_next;
    logic signed [POS_W-1:0]     prev_pos_reg,  prev_pos_next;
    logic signed [VEL_W-1:0]     last_vel_reg,  last_vel_next;

    // working registers
    logic [ANGLE_W-1:0]        raw_reg;
    logic                      ok_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [MUL_W-1:0]   tpos_reg,  tpos_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic signed [PROD_W-1:0]  prod_reg,  prod_next;
    logic                      neg_reg;
    logic                      sat_reg;
    logic [DT_W-1:0]           rem_reg,   rem_next;
    logic [QUOT_W-1:0]         quo_reg,   quo_next;
    logic [CNT_W-1:0]          cnt_reg;

    // output register
    logic [ANGLE_W-1:0]           out_angle_reg;
    logic signed [TURN_OUT_W-1:0] out_turn_reg;
    logic signed [POS_W-1:0]      out_pos_reg;
    logic signed [VEL_W-1:0]      out_vel_reg;
    logic                         out_fault_reg;

    logic signed [ANGLE_W:0]      jump;
    logic [ANGLE_W:0]             jump_mag;
    logic                         wrap;
    logic signed [SUM_W-1:0]      sum_w;
    logic signed [POS_W-1:0]      pos_w;
    logic [MAG_W-1:0]             mag_w;
    logic [DT_W+1:0]              trial_w;
    logic signed [TX_W-1:0]       turn_ext;
    logic signed [TURN_OUT_W-1:0] turn_sat;

    // wrap detection and saturating turn update
    always_comb
    begin
        jump     = $signed({1'b0, raw_reg}) - $signed({1'b0, prev_raw_reg});
        jump_mag = jump[ANGLE_W] ? $unsigned(-jump) : $unsigned(jump);
        wrap     = jump_mag > {1'b0, thr_reg};
        turns_next = turns_reg;
        if (wrap)
        begin
            if (!jump[ANGLE_W])
            begin
                if (turns_reg != TURN_MIN)
                begin
                    turns_next = turns_reg - TURN_BITS'(1);
                end
            end
            else if (turns_reg != TURN_MAX)
            begin
                turns_next = turns_reg + TURN_BITS'(1);
            end
        end
        prev_raw_next = raw_reg;
    end

    // position: turns * CPR, then add angle and clamp
    always_comb
    begin
        tpos_next = MUL_W'(turns_reg) * MUL_W'(CPR_S);
        sum_w     = SUM_W'(tpos_reg) + SUM_W'($signed({1'b0, raw_reg}));
        if (sum_w > SUM_W'(POS_MAX))
        begin
            pos_w = POS_MAX;
        end
        else if (sum_w < SUM_W'(POS_MIN))
        begin
            pos_w = POS_MIN;
        end
        else
        begin
            pos_w = POS_W'(sum_w);
        end
        prev_pos_next = pos_w;
        delta_next    = DELTA_W'(pos_w) - DELTA_W'(prev_pos_reg);
        prod_next     = PROD_W'(delta_reg) * PROD_W'(US_PER_S);
    end

    // restoring divide of |prod| by dt, high part checked for overflow first
    always_comb
    begin
        mag_w   = prod_reg[PROD_W-1] ? MAG_W'(-prod_reg) : MAG_W'(prod_reg);
        trial_w = {1'b0, rem_reg, quo_reg[QUOT_W-1]} - {2'b00, dt_reg};
        if (!trial_w[DT_W+1])
        begin
            rem_next = trial_w[DT_W-1:0];
            quo_next = {quo_reg[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = {rem_reg[DT_W-2:0], quo_reg[QUOT_W-1]};
            quo_next = {quo_reg[QUOT_W-2:0], 1'b0};
        end

        if (sat_reg)
        begin
            last_vel_next = neg_reg ? VEL_MIN : VEL_MAX;
        end
        else if (neg_reg)
        begin
            last_vel_next = (quo_reg > QUO_NEG_LIMIT) ? VEL_MIN : $signed(-quo_reg);
        end
        else
        begin
            last_vel_next = quo_reg[QUOT_W-1] ? VEL_MAX : $signed(quo_reg);
        end
    end

    // reported turns clamp to the output width
    always_comb
    begin
        turn_ext = TX_W'(turns_reg);
        if (turn_ext > TX_W'(TURN_OUT_MAX))
        begin
            turn_sat = TURN_OUT_MAX;
        end
        else if (turn_ext < TX_W'(TURN_OUT_MIN))
        begin
            turn_sat = TURN_OUT_MIN;
        end
        else
        begin
            turn_sat = TURN_OUT_W'(turn_ext);
        end
    end

    assign status.read_ok  = ok_reg;
    assign status.dt_zero  = (dt_reg == '0);
    assign status.div_sat  = (mag_w[MAG_W-1:QUOT_W] >= dt_reg);
    assign status.div_last = (cnt_reg == CNT_W'(QUOT_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= WRAP_THR_RESET;
            prev_raw_reg <= '0;
            turns_reg    <= '0;
            prev_pos_reg <= '0;
            last_vel_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.upd_turn)
            begin
                prev_raw_reg <= prev_raw_next;
                turns_reg    <= turns_next;
            end
            if (cmd.pos_sum)
            begin
                prev_pos_reg <= prev_pos_next;
            end
            if (cmd.vel_fin)
            begin
                last_vel_reg <= last_vel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            raw_reg <= in_raw_angle;
            ok_reg  <= in_read_ok;
            dt_reg  <= in_elapsed_us;
        end
        if (cmd.pos_mul)
        begin
            tpos_reg <= tpos_next;
        end
        if (cmd.pos_sum)
        begin
            delta_reg <= delta_next;
        end
        if (cmd.vel_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.div_init)
        begin
            neg_reg <= prod_reg[PROD_W-1];
            sat_reg <= status.div_sat;
            rem_reg <= mag_w[MAG_W-1:QUOT_W];
            quo_reg <= mag_w[QUOT_W-1:0];
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            out_angle_reg <= prev_raw_reg;
            out_turn_reg  <= turn_sat;
            out_pos_reg   <= prev_pos_reg;
            out_vel_reg   <= last_vel_reg;
            out_fault_reg <= !ok_reg;
        end
    end

    assign angle_counts    = out_angle_reg;
    assign turn_count      = out_turn_reg;
    assign position_counts = out_pos_reg;
    assign velocity_cps    = out_vel_reg;
    assign fault           = out_fault_reg;

endmodule

@@ rtl/core/multi_turn_encoder_tracker.sv @@
// Channel  | Dir | Payload                                                 | Handshake
// ---------+-----+---------------------------------------------------------+-----------
// in_ch    | in  | raw_angle[11:0], read_ok, elapsed_us[15:0]              | valid/ready
// out_ch   | out | angle_counts, turn_count, position_counts, velocity_cps,| valid/ready
//          |     | fault                                                   |
// cfg      | in  | cfg_wdata[11:0] -> wrap_threshold                       | cfg_we
//
// Good sample: accept, turn update, position multiply/sum, velocity
//   multiply, divide, saturate, output register; a new transaction is
//   taken once the result is registered. The 32-step restoring divider
//   for velocity dominates. Failed read: straight to output; zero elapsed
//   time: velocity held; a 32-bit quotient overflow skips the divide steps.
// Reset (rst_n low, async) clears turns, position, velocity, previous angle;
//   wrap_threshold returns to 3276.
// A result waits in the output register while out_ch is stalled; the next
//   input transaction is still taken and runs until it needs that register.
module multi_turn_encoder_tracker #(
    parameter int COUNTS_PER_REV = 4096,
    parameter int TURN_BITS      = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [met_pkg::ANGLE_W-1:0] cfg_wdata,
    met_in_if.sink                      in_ch,
    met_out_if.source                   out_ch
);
    import met_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer: accept -> turn update -> position multiply/sum ->
    // velocity multiply -> divide -> saturate -> output register.
    met_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Tracking state, arithmetic and the result register.
    met_dp #(
        .COUNTS_PER_REV (COUNTS_PER_REV),
        .TURN_BITS      (TURN_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .status          (status),
        .in_raw_angle    (in_ch.raw_angle),
        .in_read_ok      (in_ch.read_ok),
        .in_elapsed_us   (in_ch.elapsed_us),
        .angle_counts    (out_ch.angle_counts),
        .turn_count      (out_ch.turn_count),
        .position_counts (out_ch.position_counts),
        .velocity_cps    (out_ch.velocity_cps),
        .fault           (out_ch.fault)
    );

endmodule

@@ rtl/core/met_checker.sv @@
module met_checker #(
    parameter int COUNTS_PER_REV = 4096,
    parameter int TURN_BITS      = 16
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [met_pkg::ANGLE_W-1:0]           angle_counts,
    input logic signed [met_pkg::TURN_OUT_W-1:0] turn_count,
    input logic signed [met_pkg::POS_W-1:0]      position_counts,
    input logic signed [met_pkg::VEL_W-1:0]      velocity_cps,
    input logic                                  fault
);
    import met_pkg::*;

    // with one revolution = 4096 counts and 16-bit turns, position never clamps
    localparam bit POS_CHECK = (COUNTS_PER_REV == 4096) && (TURN_BITS == 16);

    // one transaction in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous item in flight");

    // position is turns and angle side by side
    a_pos_compose: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && POS_CHECK |->
            position_counts[POS_W-1:ANGLE_W] == $unsigned(turn_count) &&
            position_counts[ANGLE_W-1:0] == angle_counts)
        else $error("position does not match turns and angle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(angle_counts) && $stable(turn_count) && $stable(position_counts) &&
            $stable(velocity_cps) && $stable(fault))
        else $error("result changed while stalled");

endmodule

bind multi_turn_encoder_tracker met_checker #(
    .COUNTS_PER_REV (COUNTS_PER_REV),
    .TURN_BITS      (TURN_BITS)
) u_met_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .angle_counts    (out_ch.angle_counts),
    .turn_count      (out_ch.turn_count),
    .position_counts (out_ch.position_counts),
    .velocity_cps    (out_ch.velocity_cps),
    .fault           (out_ch.fault)
);

@@ dv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import met_pkg::*;

    localparam int COUNTS_PER_REV = 4096;
    localparam int TURN_BITS      = 16;
    localparam int TURN_MAX       = (1 << (TURN_BITS - 1)) - 1;
    localparam int TURN_MIN       = -TURN_MAX - 1;

    // flow control
    localparam int IDLE_HEAVY     = 71;   // percent of cycles idle/stalled
    localparam int IDLE_LIGHT     = 15;
    localparam int HOLD_CYCLES    = 400;  // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000; // cycles with no transaction on either side
    localparam int DRAIN_CYCLES   = 50;   // a bit over one good-sample latency
    localparam int PHASE_ITEMS    = 200;
    localparam int SWEEP_LEN      = 4096;
    localparam int SWEEP_ITEMS    = 128;

    typedef struct packed {
        logic [ANGLE_W-1:0] raw;
        logic               ok;
        logic [DT_W-1:0]    dt;
    } encoder_sample_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]           angle;
        logic signed [TURN_OUT_W-1:0] turns;
        logic signed [POS_W-1:0]      pos;
        logic signed [VEL_W-1:0]      vel;
        logic                         fault;
    } tracker_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [ANGLE_W-1:0]  cfg_wdata;

    met_in_if  in_ch ();
    met_out_if out_ch ();

    multi_turn_encoder_tracker #(
        .COUNTS_PER_REV (COUNTS_PER_REV),
        .TURN_BITS      (TURN_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // samples waiting for the driver, and the tracker outputs still owed by the block
    encoder_sample_t samples_pending[$];
    tracker_result_t results_due[$];

    // flow-control knobs, written by the stimulus process
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int holds_asked   = 0;

    // receiver-side hold-off bookkeeping
    int hold_left;
    int holds_granted;

    int errors = 0;
    int quiet_cycles = 0;

    // last good angle as seen by the stimulus generator, so rotation steps
    // continue from what the block actually holds
    logic [ANGLE_W-1:0] gen_angle = '0;

    // ------------------------------------------------------------------
    // Tracker prediction: private copy of the block's state and register
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] trk_angle    = '0;
    int                 trk_turns    = 0;
    longint             trk_pos      = 0;
    longint             trk_rate     = 0;
    logic [ANGLE_W-1:0] trk_wrap_thr = WRAP_THR_RESET;

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the predicted tracker by one sample and return the result the
    // block must produce for it.
    function automatic tracker_result_t track_sample(encoder_sample_t s);
        int              jump;
        longint          pos;
        tracker_result_t r;
        if (s.ok)
        begin
            jump = int'(s.raw) - int'(trk_angle);
            // a jump larger than the threshold means the angle crossed zero:
            // going up means we really went backward a turn, and vice versa
            if ((jump < 0 ? -jump : jump) > int'(trk_wrap_thr))
            begin
                if (jump > 0 && trk_turns > TURN_MIN)
                    trk_turns--;
                else if (jump < 0 && trk_turns < TURN_MAX)
                    trk_turns++;
            end
            trk_angle = s.raw;
            pos = clamp(longint'(trk_turns) * COUNTS_PER_REV + longint'(s.raw),
                        POS_MIN, POS_MAX);
            // zero elapsed time keeps the previous velocity
            if (s.dt != '0)
                trk_rate = clamp((pos - trk_pos) * longint'(US_PER_S) / longint'(s.dt),
                                 VEL_MIN, VEL_MAX);
            trk_pos = pos;
        end
        // a failed read leaves every state alone and just flags the fault
        r.angle = trk_angle;
        r.turns = TURN_OUT_W'(clamp(trk_turns, TURN_OUT_MIN, TURN_OUT_MAX));
        r.pos   = POS_W'(trk_pos);
        r.vel   = VEL_W'(trk_rate);
        r.fault = !s.ok;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Input driver: if the channel is free, pops the next sample or idles.
    // valid stays up across back-to-back transactions (one NBA per edge).
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        encoder_sample_t sample;
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.raw_angle  <= '0;
            in_ch.read_ok    <= 1'b0;
            in_ch.elapsed_us <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (samples_pending.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                sample = samples_pending.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.raw_angle  <= sample.raw;
                in_ch.read_ok    <= sample.ok;
                in_ch.elapsed_us <= sample.dt;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output receiver: random stalls, plus a long hold-off on request so
    // the block backs up and stops taking input.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready  <= 1'b0;
            hold_left     <= 0;
            holds_granted <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (holds_granted != holds_asked)
        begin
            holds_granted <= holds_granted + 1;
            hold_left     <= HOLD_CYCLES;
            out_ch.ready  <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // every accepted input transaction yields exactly one expected result
    always @(posedge clk)
    begin
        encoder_sample_t taken;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            taken.raw = in_ch.raw_angle;
            taken.ok  = in_ch.read_ok;
            taken.dt  = in_ch.elapsed_us;
            results_due.push_back(track_sample(taken));
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: in-order, field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tracker_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected output transaction: no sample outstanding");
                errors++;
            end
            else
            begin
                want = results_due.pop_front();
                if (out_ch.angle_counts !== want.angle)
                begin
                    $error("angle_counts: expected %0d, got %0d", want.angle,
                           out_ch.angle_counts);
                    errors++;
                end
                if (out_ch.turn_count !== want.turns)
                begin
                    $error("turn_count: expected %0d, got %0d", want.turns, out_ch.turn_count);
                    errors++;
                end
                if (out_ch.position_counts !== want.pos)
                begin
                    $error("position_counts: expected %0d, got %0d", want.pos,
                           out_ch.position_counts);
                    errors++;
                end
                if (out_ch.velocity_cps !== want.vel)
                begin
                    $error("velocity_cps: expected %0d, got %0d", want.vel,
                           out_ch.velocity_cps);
                    errors++;
                end
                if (out_ch.fault !== want.fault)
                begin
                    $error("fault: expected %0d, got %0d", want.fault, out_ch.fault);
                    errors++;
                end
            end
        end
    end

    // watchdog: a hang shows up as a long run with no transaction anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_sample(input logic [ANGLE_W-1:0] raw, input logic ok,
                                input logic [DT_W-1:0] dt);
        encoder_sample_t s;
        s.raw = raw;
        s.ok  = ok;
        s.dt  = dt;
        samples_pending.push_back(s);
        if (ok)
            gen_angle = raw;
    endtask

    // sender stops until the block has returned everything it owes
    task automatic wait_idle();
        while (samples_pending.size() != 0 || in_ch.valid || results_due.size() != 0)
            @(posedge clk);
    endtask

    // only called with the block idle
    task automatic set_wrap_threshold(input logic [ANGLE_W-1:0] value);
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= value;
        trk_wrap_thr  = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_flow(input int src_pct, input int snk_pct);
        @(posedge clk);
        src_idle_pct  <= src_pct;
        snk_stall_pct <= snk_pct;
    endtask

    // Mostly smooth rotation with random speed and direction; the rest is
    // failed reads, zero-time samples and raw noise.
    task automatic run_random_phase(input int count);
        int              spread;
        int              kind;
        int              step;
        int              pick;
        logic [DT_W-1:0] dt;
        spread = 16;
        for (int i = 0; i < count; i++)
        begin
            if (i % 32 == 0)
            begin
                case ($urandom_range(3))
                    0:       spread = 16;
                    1:       spread = 300;
                    2:       spread = 1500;
                    default: spread = 4095;
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 70)
                dt = DT_W'($urandom_range(100, 5000));
            else if (pick < 85)
                dt = DT_W'($urandom_range(1, 99));
            else
                dt = DT_W'($urandom_range(65535));
            step = int'($urandom_range(2 * spread)) - spread;
            kind = $urandom_range(99);
            if (kind < 70)
                queue_sample(ANGLE_W'(int'(gen_angle) + step), 1'b1, dt);
            else if (kind < 80)
                queue_sample(ANGLE_W'($urandom), 1'b0, DT_W'($urandom));
            else if (kind < 88)
                queue_sample(ANGLE_W'(int'(gen_angle) + step), 1'b1, '0);
            else
                queue_sample(ANGLE_W'($urandom), 1'b1, DT_W'($urandom));
        end
        wait_idle();
    endtask

    // One count per sample: with a zero threshold every step is a wrap.
    // Zero elapsed time keeps each transaction short.
    task automatic queue_sweep(input int count, input bit downward);
        for (int a = 0; a < count; a++)
            queue_sample(downward ? ANGLE_W'(a) : ANGLE_W'(SWEEP_LEN - 1 - a), 1'b1, '0);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.raw_angle  = '0;
        in_ch.read_ok    = 1'b0;
        in_ch.elapsed_us = '0;
        out_ch.ready     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed samples, threshold still at its reset value
        queue_sample(12'd4000, 1'b1, 16'd1);     // first sample after reset wraps vs zero
        queue_sample(12'd123,  1'b0, 16'd500);   // failed read repeats old state
        queue_sample(12'd0,    1'b1, 16'd65535); // unwrap back, longest interval
        queue_sample(12'd4095, 1'b1, 16'd1);
        queue_sample(12'd4095, 1'b1, 16'd0);     // zero elapsed time holds velocity
        queue_sample(12'd819,  1'b1, 16'd1);     // jump equal to threshold: no wrap,
                                                 // velocity clips negative
        queue_sample(12'd4095, 1'b1, 16'd1);     // velocity clips positive
        queue_sample(12'd818,  1'b1, 16'd3);     // one past threshold: wrap
        queue_sample(12'd817,  1'b1, 16'd3);     // -1e6/3 truncates toward zero
        queue_sample(12'd818,  1'b1, 16'd3);
        queue_sample(12'd0,    1'b0, 16'd0);     // failed read with zero time
        queue_sample(12'd2048, 1'b1, 16'd7);
        queue_sample(12'd0,    1'b1, 16'd65535);
        queue_sample(12'hAAA,  1'b1, 16'hAAAA);
        queue_sample(12'h555,  1'b1, 16'h5555);
        queue_sample(12'hFFF,  1'b0, 16'hFFFF);
        wait_idle();

        // highest threshold: no wrap is ever possible. Free flow, with one
        // long receiver hold-off while the sender keeps offering.
        set_wrap_threshold(12'd4095);
        set_flow(0, 0);
        holds_asked <= holds_asked + 1;
        run_random_phase(PHASE_ITEMS);

        // zero threshold: any movement counts as a wrap
        set_wrap_threshold(12'd0);
        set_flow(IDLE_HEAVY, 0);
        run_random_phase(PHASE_ITEMS);

        set_wrap_threshold(ANGLE_W'($urandom_range(4095)));
        set_flow(0, IDLE_HEAVY);
        run_random_phase(PHASE_ITEMS);

        set_wrap_threshold(12'd2048);
        set_flow(IDLE_LIGHT, IDLE_LIGHT);
        run_random_phase(PHASE_ITEMS);

        set_wrap_threshold(ANGLE_W'($urandom_range(4095)));
        set_flow(0, 0);
        run_random_phase(PHASE_ITEMS);

        // zero threshold: every one-count step is a wrap, in both directions
        set_wrap_threshold(12'd0);
        queue_sweep(SWEEP_ITEMS, 1'b1);
        queue_sweep(SWEEP_ITEMS, 1'b0);

        // back to the reset threshold, mixed flow
        set_wrap_threshold(WRAP_THR_RESET);
        set_flow(IDLE_LIGHT, IDLE_LIGHT);
        run_random_phase(PHASE_ITEMS);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && results_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/met_pkg.sv
rtl/core/met_in_if.sv
rtl/core/met_out_if.sv
rtl/core/met_ctrl.sv
rtl/core/met_dp.sv
rtl/core/multi_turn_encoder_tracker.sv
rtl/core/met_checker.sv
dv/testbench.sv
